/* design/stpq_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stpq_pkg
// shared types and constants for the stable sorted priority queue
// ----------------------------------------------------------------------------
package stpq_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int PRIO_BITS = 3;
    localparam int TAG_BITS  = 16;
    localparam int OCC_BITS  = 5;
    localparam int STAT_BITS = 2;

    // operation codes
    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_REMOVE = 1'b1;

    // status codes
    localparam logic [STAT_BITS-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_BITS-1:0] ST_EMPTY = 2'd1;
    localparam logic [STAT_BITS-1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic                 func;
        logic [PRIO_BITS-1:0] priority_req;
        logic [TAG_BITS-1:0]  tag;
    } t_request;

    typedef struct packed {
        logic                 removed_valid;
        logic [PRIO_BITS-1:0] removed_priority;
        logic [TAG_BITS-1:0]  removed_tag;
        logic [STAT_BITS-1:0] status;
        logic [OCC_BITS-1:0]  occupancy;
    } t_result;

    // controller to datapath commands
    typedef struct packed {
        logic ins;
        logic rem;
        logic capture;
    } t_dp_cmd;

endpackage

/* design/stpq_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stpq_ctrl
// occupancy tracking, full and empty decisions, result strobe and status
// ----------------------------------------------------------------------------
module stpq_ctrl #(
    parameter int DEPTH = stpq_pkg::DEPTH_DEF,
    parameter int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_accept,
    input  logic                            i_func,
    output stpq_pkg::t_dp_cmd               o_cmd,
    output logic [CNT_W-1:0]                o_count,
    output logic                            o_busy,
    output logic                            o_done,
    output logic                            o_removed_valid,
    output logic [stpq_pkg::STAT_BITS-1:0]  o_status,
    output logic [stpq_pkg::OCC_BITS-1:0]   o_occupancy
);

    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    logic [CNT_W-1:0]               r_count, n_count;
    logic                           r_init;
    logic                           r_done;
    logic                           r_rvalid;
    logic [stpq_pkg::STAT_BITS-1:0] r_status, n_status;
    logic                           is_full, is_empty;

    assign is_full  = (r_count == FULL_CNT);
    assign is_empty = (r_count == '0);

    always_comb begin
        o_cmd         = '0;
        n_count       = r_count;
        n_status      = stpq_pkg::ST_OK;
        o_cmd.capture = i_accept;
        if (i_accept) begin
            unique case (i_func)
                stpq_pkg::FUNC_INSERT: begin
                    if (is_full) begin
                        n_status = stpq_pkg::ST_FULL;
                    end else begin
                        o_cmd.ins = 1'b1;
                        n_count   = r_count + CNT_W'(1);
                    end
                end
                stpq_pkg::FUNC_REMOVE: begin
                    if (is_empty) begin
                        n_status = stpq_pkg::ST_EMPTY;
                    end else begin
                        o_cmd.rem = 1'b1;
                        n_count   = r_count - CNT_W'(1);
                    end
                end
                default: n_status = stpq_pkg::ST_OK;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_init   <= 1'b1;
            r_done   <= 1'b0;
            r_rvalid <= 1'b0;
            r_status <= stpq_pkg::ST_OK;
        end else begin
            r_init   <= 1'b0;
            r_count  <= n_count;
            r_done   <= i_accept;
            r_rvalid <= o_cmd.rem;
            r_status <= n_status;
        end
    end

    // result occupancy reflects the count after the item
    generate
        if (CNT_W >= stpq_pkg::OCC_BITS) begin : g_occ_trunc
            assign o_occupancy = r_count[stpq_pkg::OCC_BITS-1:0];
        end else begin : g_occ_ext
            assign o_occupancy = {{(stpq_pkg::OCC_BITS-CNT_W){1'b0}}, r_count};
        end
    endgenerate

    assign o_count         = r_count;
    assign o_busy          = r_init;
    assign o_done          = r_done;
    assign o_removed_valid = r_rvalid;
    assign o_status        = r_status;

endmodule

/* design/stpq_dpath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stpq_dpath
// sorted cell chain holding priority and tag, plus the removed word register
// ----------------------------------------------------------------------------
module stpq_dpath #(
    parameter int DEPTH = stpq_pkg::DEPTH_DEF,
    parameter int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic                            i_clk,
    input  stpq_pkg::t_dp_cmd               i_cmd,
    input  logic [CNT_W-1:0]                i_count,
    input  logic [stpq_pkg::PRIO_BITS-1:0]  i_prio,
    input  logic [stpq_pkg::TAG_BITS-1:0]   i_tag,
    output logic [stpq_pkg::PRIO_BITS-1:0]  o_removed_priority,
    output logic [stpq_pkg::TAG_BITS-1:0]   o_removed_tag
);

    logic [stpq_pkg::PRIO_BITS-1:0] r_prio [DEPTH];
    logic [stpq_pkg::TAG_BITS-1:0]  r_tag  [DEPTH];
    logic [stpq_pkg::PRIO_BITS-1:0] r_rm_prio;
    logic [stpq_pkg::TAG_BITS-1:0]  r_rm_tag;
    logic [DEPTH-1:0]               behind; // cell sits at or behind the insert point

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cell
            logic is_new;
            // empty cells and less urgent cells lie behind the new entry
            assign behind[gi] = (CNT_W'(gi) >= i_count) || (r_prio[gi] > i_prio);

            if (gi == 0) begin : g_head
                assign is_new = behind[0];
            end else begin : g_body
                assign is_new = behind[gi] && !behind[gi-1];
            end

            always_ff @(posedge i_clk) begin
                if (i_cmd.ins) begin
                    if (is_new) begin
                        r_prio[gi] <= i_prio;
                        r_tag[gi]  <= i_tag;
                    end else if (behind[gi]) begin
                        if (gi > 0) begin
                            r_prio[gi] <= r_prio[(gi > 0) ? gi-1 : 0];
                            r_tag[gi]  <= r_tag[(gi > 0) ? gi-1 : 0];
                        end
                    end
                end else if (i_cmd.rem) begin
                    if (gi < DEPTH-1) begin
                        r_prio[gi] <= r_prio[(gi < DEPTH-1) ? gi+1 : gi];
                        r_tag[gi]  <= r_tag[(gi < DEPTH-1) ? gi+1 : gi];
                    end
                end
            end
        end
    endgenerate

    // removed word: head cell on a real remove, zero on any other accepted word
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            if (i_cmd.rem) begin
                r_rm_prio <= r_prio[0];
                r_rm_tag  <= r_tag[0];
            end else begin
                r_rm_prio <= '0;
                r_rm_tag  <= '0;
            end
        end
    end

    assign o_removed_priority = r_rm_prio;
    assign o_removed_tag      = r_rm_tag;

endmodule

/* design/stable_priority_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stable_priority_queue
// bounded priority queue kept sorted in a chain of cells, stable on ties
// ----------------------------------------------------------------------------
// A word is taken on any clock edge where start is high and busy is low; busy
// is set by reset and clears once reset is released, so a word can then be
// issued every cycle. Each word gives exactly one result word, shown on
// o_result for one cycle with o_done high, in the cycle after the word is
// taken; there is no backpressure, so the receiver must capture it in that
// cycle. Throughput is one word per cycle once busy is low: every cell of the
// chain compares its priority against the new entry in parallel and shifts
// or loads at once, and a remove shifts the whole chain forward the same way.
// Lower priority values are served first, and entries of equal priority leave
// in arrival order. A remove on an empty queue reports status empty, an insert
// into a full queue is dropped with status full; both leave the queue as is.
// ----------------------------------------------------------------------------
module stable_priority_queue #(
    parameter int DEPTH = stpq_pkg::DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  stpq_pkg::t_request i_cmd,
    output logic               o_done,
    output stpq_pkg::t_result  o_result
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    stpq_pkg::t_dp_cmd              dp_cmd;
    logic [CNT_W-1:0]               count;
    logic                           accept;
    logic                           rm_valid;
    logic [stpq_pkg::STAT_BITS-1:0] status;
    logic [stpq_pkg::OCC_BITS-1:0]  occupancy;
    logic [stpq_pkg::PRIO_BITS-1:0] rm_prio;
    logic [stpq_pkg::TAG_BITS-1:0]  rm_tag;

    // word handshake
    assign accept = start && !busy;

    // controller: count, full and empty checks, strobe and status
    stpq_ctrl #(
        .DEPTH (DEPTH),
        .CNT_W (CNT_W)
    ) u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (accept),
        .i_func          (i_cmd.func),
        .o_cmd           (dp_cmd),
        .o_count         (count),
        .o_busy          (busy),
        .o_done          (o_done),
        .o_removed_valid (rm_valid),
        .o_status        (status),
        .o_occupancy     (occupancy)
    );

    // datapath: sorted cell chain and removed word register
    stpq_dpath #(
        .DEPTH (DEPTH),
        .CNT_W (CNT_W)
    ) u_dpath (
        .i_clk              (i_clk),
        .i_cmd              (dp_cmd),
        .i_count            (count),
        .i_prio             (i_cmd.priority_req),
        .i_tag              (i_cmd.tag),
        .o_removed_priority (rm_prio),
        .o_removed_tag      (rm_tag)
    );

    // result word assembly
    always_comb begin
        o_result                  = '0;
        o_result.removed_valid    = rm_valid;
        o_result.removed_priority = rm_prio;
        o_result.removed_tag      = rm_tag;
        o_result.status           = status;
        o_result.occupancy        = occupancy;
    end

endmodule
